// ===== hw/rtl/sdof_pkg.sv =====
// shared types and constants for the stereo disparity occlusion filter
// no dependencies; used by sdof_ctrl, sdof_dp and the top level

package sdof_pkg;

  localparam logic [1:0] CFG_SCALE     = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH = 2'd1;
  localparam logic [1:0] CFG_MIN_DISP  = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] disparity;
  } pixel_t;

  typedef struct packed {
    logic [7:0] clean_disparity;
    logic [9:0] column;
    logic       last_of_row;
    logic       valid_res;
  } result_t;

  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_FWD,
    SW_BWD,
    SW_OUT
  } sweep_mode_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_CLEAR,
    S_LOAD_IDLE,
    S_LOAD_WR,
    S_PASS1,
    S_PASS2,
    S_PASS3,
    S_READ_IDLE,
    S_READ_WAIT
  } state_t;

  typedef struct packed {
    logic        load_issue;
    logic        load_commit;
    logic        read_commit;
    logic        zero_result;
    logic        sweep_start;
    sweep_mode_t sweep_mode;
  } dp_cmd_t;

  typedef struct packed {
    logic load_full;
    logic sweep_done;
    logic read_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/stereo_disparity_occlusion_filter_unit.sv =====
// stereo disparity occlusion filter, top level: controller plus datapath
// a load request passes through S_LOAD_WR, a read request in readout through S_READ_WAIT;
// a read while loading gets a zero result; the last load of a row starts three sweeps
// of the gaze buffer, which holds GBUF = 2 * MAX_SCALE * (MAX_WIDTH - 1) + 256 entries
// after rst a clearing sweep runs; config writes are taken throughout, pixel requests
// stall until it ends; depends on sdof_pkg

module stereo_disparity_occlusion_filter_unit import sdof_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  // pixel requests: loads and reads
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  pixel_t      pixel,
  // result requests, one per read
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // registers accept writes in every cycle
  assign cfg_ready = 1'b1;

  // sequencing: row loading, the three cleaning sweeps and readout
  sdof_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_kind  (pixel.kind),
    .pixel_stall (pixel_stall),
    .cmd         (cmd),
    .status      (status)
  );

  // storage, sweep arithmetic and the result register
  sdof_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== hw/rtl/sdof_ctrl.sv =====
// controller state machine: request sequencing, row phases and sweep passes
// depends on sdof_pkg

module sdof_ctrl import sdof_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  input  logic       pixel_kind,
  output logic       pixel_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state, state_next;
  logic   can_take;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    can_take    = ((state == S_LOAD_IDLE) || (state == S_READ_IDLE)) && status.out_free;
    accept      = pixel_valid && can_take;
    pixel_stall = !can_take;
    state_next  = state;
    cmd         = '0;
    cmd.sweep_mode = SW_CLEAR;
    case (state)
      S_INIT: begin
        cmd.sweep_start = 1'b1;
        cmd.sweep_mode  = SW_CLEAR;
        state_next      = S_CLEAR;
      end
      S_CLEAR: begin
        if (status.sweep_done) state_next = S_LOAD_IDLE;
      end
      S_LOAD_IDLE: begin
        if (accept) begin
          if (pixel_kind == KIND_LOAD) begin
            cmd.load_issue = 1'b1;
            state_next     = S_LOAD_WR;
          end else begin
            cmd.zero_result = 1'b1;
          end
        end
      end
      S_LOAD_WR: begin
        cmd.load_commit = 1'b1;
        if (status.load_full) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = SW_FWD;
          state_next      = S_PASS1;
        end else begin
          state_next = S_LOAD_IDLE;
        end
      end
      S_PASS1: begin
        if (status.sweep_done) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = SW_BWD;
          state_next      = S_PASS2;
        end
      end
      S_PASS2: begin
        if (status.sweep_done) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = SW_OUT;
          state_next      = S_PASS3;
        end
      end
      S_PASS3: begin
        if (status.sweep_done) state_next = S_READ_IDLE;
      end
      S_READ_IDLE: begin
        // loads during readout are dropped
        if (accept && (pixel_kind == KIND_READ)) state_next = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        cmd.read_commit = 1'b1;
        state_next      = status.read_last ? S_LOAD_IDLE : S_READ_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sdof_dp.sv =====
// datapath: config registers, gaze-line buffer, cleaned-row store, sweep unit
// and result register; depends on sdof_pkg

module sdof_dp import sdof_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  pixel_t      pixel,
  input  logic        result_stall,
  output logic        result_valid,
  output result_t     result,
  input  dp_cmd_t     cmd,
  output dp_status_t  status
);

  localparam int GBUF = MAX_SCALE * 2 * (MAX_WIDTH - 1) + 256;
  localparam int AW   = $clog2(GBUF);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int LCW  = $clog2(MAX_WIDTH + 1);
  localparam int LW   = AW + LCW;
  localparam int EW   = 8 + CW;
  localparam int PW   = LCW + 12;

  // configuration
  logic [2:0]  scale;
  logic [10:0] row_width;
  logic [8:0]  min_disparity;
  logic [2:0]  eff_sc;
  logic [LCW-1:0] eff_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= 3'd1;
      row_width     <= 11'd1024;
      min_disparity <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE:     scale         <= cfg_data[2:0];
        CFG_ROW_WIDTH: row_width     <= cfg_data;
        CFG_MIN_DISP:  min_disparity <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale == 3'd0) eff_sc = 3'd1;
    else if (32'(scale) > MAX_SCALE) eff_sc = 3'(MAX_SCALE);
    else eff_sc = scale;
    if (row_width == 11'd0) eff_w = LCW'(1);
    else if (32'(row_width) > MAX_WIDTH) eff_w = LCW'(MAX_WIDTH);
    else eff_w = LCW'(row_width);
  end

  // gaze-line buffer
  logic [EW-1:0] gbuf [GBUF];
  logic          g_we;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [EW-1:0] g_wdata, g_rdata;

  always_ff @(posedge clk) begin
    if (g_we) gbuf[g_waddr] <= g_wdata;
    g_rdata <= gbuf[g_raddr];
  end

  // cleaned row store
  logic [7:0]    rowmem [MAX_WIDTH];
  logic          r_we;
  logic [CW-1:0] r_waddr;
  logic [7:0]    r_wdata, r_rdata;
  logic [CW-1:0] rc;

  always_ff @(posedge clk) begin
    if (r_we) rowmem[r_waddr] <= r_wdata;
    r_rdata <= rowmem[rc];
  end

  // load path
  logic [LCW-1:0] lc, lc_new;
  logic [LW-1:0]  load_w;
  logic [AW-1:0]  lw_q;
  logic [7:0]     disp_q;
  logic           lc_room;

  assign load_w  = LW'(eff_sc) * LW'(lc) * LW'(2) + LW'(pixel.disparity);
  assign lc_room = (32'(lc) < MAX_WIDTH);
  assign lc_new  = lc + LCW'(lc_room);

  // sweep unit
  sweep_mode_t   mode_q;
  logic          issuing, p_valid, p_last;
  logic [AW-1:0] ptr, p_addr, ptr_end;
  logic [AW:0]   fwd_max, fwd_key;
  logic signed [AW+1:0] bwd_max, bwd_key;
  logic          bwd_seen;
  logic [7:0]    ss;
  logic [CW-1:0] s_col;

  assign ss      = g_rdata[EW-1:CW];
  assign s_col   = g_rdata[CW-1:0];
  assign fwd_key = (AW+1)'(p_addr) + (AW+1)'(ss);
  assign bwd_key = $signed((AW+2)'(ss)) - $signed((AW+2)'(p_addr));
  assign ptr_end = (mode_q == SW_BWD) ? '0 : AW'(GBUF - 1);
  assign g_raddr = issuing ? ptr : load_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      p_valid <= 1'b0;
    end else if (cmd.sweep_start) begin
      issuing <= 1'b1;
      p_valid <= 1'b0;
    end else begin
      p_valid <= issuing;
      if (issuing && (ptr == ptr_end)) issuing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      mode_q   <= cmd.sweep_mode;
      ptr      <= (cmd.sweep_mode == SW_BWD) ? AW'(GBUF - 1) : '0;
      fwd_max  <= '0;
      bwd_seen <= 1'b0;
      bwd_max  <= '0;
    end else begin
      if (issuing) begin
        p_addr <= ptr;
        p_last <= (ptr == ptr_end);
        ptr    <= (mode_q == SW_BWD) ? ptr - AW'(1) : ptr + AW'(1);
      end
      if (p_valid && (ss != 8'd0)) begin
        if ((mode_q == SW_FWD) && (fwd_key > fwd_max)) fwd_max <= fwd_key;
        if (mode_q == SW_BWD) begin
          if (!bwd_seen || (bwd_key > bwd_max)) bwd_max <= bwd_key;
          bwd_seen <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = p_addr;
    g_wdata = '0;
    r_we    = 1'b0;
    r_waddr = p_addr[CW-1:0];
    r_wdata = 8'd0;
    if (p_valid) begin
      case (mode_q)
        SW_CLEAR: g_we = 1'b1;
        SW_FWD: begin
          // right-side occlusion by an earlier surviving entry
          g_we = (ss != 8'd0) && !(fwd_key > fwd_max);
          r_we = ((AW+1)'(p_addr) < (AW+1)'(MAX_WIDTH));
        end
        SW_BWD: g_we = (ss != 8'd0) && bwd_seen && (bwd_key <= bwd_max);
        SW_OUT: begin
          g_we    = 1'b1;
          r_we    = (ss != 8'd0);
          r_waddr = s_col;
          r_wdata = ss;
        end
        default: g_we = 1'b0;
      endcase
    end else if (cmd.load_commit && (disp_q != 8'd0) && lc_room
                 && (disp_q > g_rdata[EW-1:CW])) begin
      g_we    = 1'b1;
      g_waddr = lw_q;
      g_wdata = {disp_q, lc[CW-1:0]};
    end
  end

  // readout
  logic [LCW-1:0] diff;
  logic [PW-1:0]  prod;
  logic           in_range, keep, last;
  logic [CW+9:0]  col_ext;

  assign in_range = eff_w > LCW'(rc);
  assign diff     = eff_w - LCW'(rc);
  assign prod     = PW'(eff_sc) * PW'(diff);
  assign keep     = in_range && (PW'(min_disparity) < prod);
  assign last     = ((LCW+1)'(rc) + (LCW+1)'(1)) >= (LCW+1)'(eff_w);
  assign col_ext  = (CW+10)'(rc);

  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= '0;
      rc <= '0;
    end else begin
      if (cmd.load_commit) lc <= lc_new;
      if (cmd.read_commit) begin
        if (last) begin
          lc <= '0;
          rc <= '0;
        end else begin
          rc <= rc + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_issue) begin
      lw_q   <= load_w[AW-1:0];
      disp_q <= pixel.disparity;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.zero_result || cmd.read_commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_result) begin
      result <= '0;
    end else if (cmd.read_commit) begin
      result.clean_disparity <= keep ? r_rdata : 8'd0;
      result.column          <= col_ext[9:0];
      result.last_of_row     <= last;
      result.valid_res       <= 1'b1;
    end
  end

  assign status.load_full  = (lc_new >= eff_w);
  assign status.sweep_done = p_valid && p_last;
  assign status.read_last  = last;
  assign status.out_free   = !result_valid || !result_stall;

endmodule
